### src/dbpd_pkg.sv
`default_nettype none

package dbpd_pkg;

  localparam int DistW = 8;
  localparam int TickW = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [DistW-1:0] DefNoObjectCode = 8'd255;
  localparam logic [TickW-1:0] DefIdleOffTicks = 16'd100;
  localparam logic [TickW-1:0] DefSteadyOnTicks = 16'd100;
  localparam logic [TickW-1:0] DefSteadyOffTicks = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FAR_LIMIT      = 3'd0,
    REG_MID_LIMIT      = 3'd1,
    REG_NEAR_LIMIT     = 3'd2,
    REG_CONTACT_LIMIT  = 3'd3,
    REG_BEEP_ON_TICKS  = 3'd4,
    REG_FAR_OFF_TICKS  = 3'd5,
    REG_MID_OFF_TICKS  = 3'd6,
    REG_NEAR_OFF_TICKS = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    LVL_SILENT = 3'd0,
    LVL_FAR    = 3'd1,
    LVL_MID    = 3'd2,
    LVL_NEAR   = 3'd3,
    LVL_STEADY = 3'd4
  } level_t;

  typedef struct packed {
    logic [DistW-1:0] far_limit;
    logic [DistW-1:0] mid_limit;
    logic [DistW-1:0] near_limit;
    logic [DistW-1:0] contact_limit;
    logic [TickW-1:0] beep_on_ticks;
    logic [TickW-1:0] far_off_ticks;
    logic [TickW-1:0] mid_off_ticks;
    logic [TickW-1:0] near_off_ticks;
  } cfg_t;

  typedef struct packed {
    logic   speaker_on;
    level_t alarm_level;
  } result_t;

endpackage

`default_nettype wire

### src/distance_beep_pattern_driver.sv
// A word accepted into the input register moves into the result register, and so to
// the output, once the result register is free or being drained.
// Throughput: one word per cycle unless the output stalls; the input and result registers
// overlap, and the beep state is updated as a word moves into the result register.
// Reset (rst, synchronous, active high) restores register defaults, the silent level
// and an empty pipeline; no clearing pass is needed.
`default_nettype none

module distance_beep_pattern_driver
  import dbpd_pkg::*;
#(
  parameter logic [DistW-1:0] NO_OBJECT_CODE   = DefNoObjectCode,
  parameter logic [TickW-1:0] IDLE_OFF_TICKS   = DefIdleOffTicks,
  parameter logic [TickW-1:0] STEADY_ON_TICKS  = DefSteadyOnTicks,
  parameter logic [TickW-1:0] STEADY_OFF_TICKS = DefSteadyOffTicks
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [DistW-1:0]    nearest_distance,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     speaker_on,
  output logic [2:0]               alarm_level
);

  cfg_t             cfg;
  result_t          result;
  logic             s1_valid;
  logic [DistW-1:0] s1_distance;
  logic             advance;
  logic             in_take;

  dbpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dbpd_core #(
    .NO_OBJECT_CODE   (NO_OBJECT_CODE),
    .IDLE_OFF_TICKS   (IDLE_OFF_TICKS),
    .STEADY_ON_TICKS  (STEADY_ON_TICKS),
    .STEADY_OFF_TICKS (STEADY_OFF_TICKS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .distance (s1_distance),
    .cfg      (cfg),
    .result   (result)
  );

  // A word moves on whenever the result register is empty or being drained.
  assign advance  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_distance <= nearest_distance;
    end
    if (advance) begin
      speaker_on  <= result.speaker_on;
      alarm_level <= result.alarm_level;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_distance))
    else $error("held input word lost");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> alarm_level <= LVL_STEADY)
    else $error("alarm level out of range");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded");

endmodule

`default_nettype wire

### src/dbpd_cfg.sv
`default_nettype none

module dbpd_cfg
  import dbpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.far_limit      <= 8'd150;
      cfg.mid_limit      <= 8'd100;
      cfg.near_limit     <= 8'd60;
      cfg.contact_limit  <= 8'd35;
      cfg.beep_on_ticks  <= 16'd100;
      cfg.far_off_ticks  <= 16'd400;
      cfg.mid_off_ticks  <= 16'd200;
      cfg.near_off_ticks <= 16'd100;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_FAR_LIMIT:      cfg.far_limit      <= cfg_data[DistW-1:0];
        REG_MID_LIMIT:      cfg.mid_limit      <= cfg_data[DistW-1:0];
        REG_NEAR_LIMIT:     cfg.near_limit     <= cfg_data[DistW-1:0];
        REG_CONTACT_LIMIT:  cfg.contact_limit  <= cfg_data[DistW-1:0];
        REG_BEEP_ON_TICKS:  cfg.beep_on_ticks  <= cfg_data[TickW-1:0];
        REG_FAR_OFF_TICKS:  cfg.far_off_ticks  <= cfg_data[TickW-1:0];
        REG_MID_OFF_TICKS:  cfg.mid_off_ticks  <= cfg_data[TickW-1:0];
        REG_NEAR_OFF_TICKS: cfg.near_off_ticks <= cfg_data[TickW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/dbpd_core.sv
`default_nettype none

module dbpd_core
  import dbpd_pkg::*;
#(
  parameter logic [DistW-1:0] NO_OBJECT_CODE   = DefNoObjectCode,
  parameter logic [TickW-1:0] IDLE_OFF_TICKS   = DefIdleOffTicks,
  parameter logic [TickW-1:0] STEADY_ON_TICKS  = DefSteadyOnTicks,
  parameter logic [TickW-1:0] STEADY_OFF_TICKS = DefSteadyOffTicks
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic [DistW-1:0] distance,
  input  cfg_t                  cfg,
  output result_t               result
);

  logic [DistW-1:0] held_distance, held_distance_next;
  logic [TickW-1:0] on_length, on_length_next;
  logic [TickW-1:0] off_length, off_length_next;
  logic [TickW-1:0] phase_count, phase_count_next;
  logic             phase_high, phase_high_next;
  logic             silent_mark, silent_mark_next;
  logic             steady_mark, steady_mark_next;
  logic             drive_level, drive_level_next;
  level_t           level_held, level_held_next;

  // Level selection runs only when the distance differs from the held one.
  always_comb begin
    held_distance_next = held_distance;
    on_length_next     = on_length;
    off_length_next    = off_length;
    silent_mark_next   = silent_mark;
    steady_mark_next   = steady_mark;
    level_held_next    = level_held;
    if (distance != held_distance) begin
      held_distance_next = distance;
      silent_mark_next   = 1'b0;
      steady_mark_next   = 1'b0;
      if (distance > cfg.far_limit) begin
        held_distance_next = NO_OBJECT_CODE;
        on_length_next     = '0;
        off_length_next    = IDLE_OFF_TICKS;
        silent_mark_next   = 1'b1;
        level_held_next    = LVL_SILENT;
      end else if (distance > cfg.mid_limit) begin
        on_length_next  = cfg.beep_on_ticks;
        off_length_next = cfg.far_off_ticks;
        level_held_next = LVL_FAR;
      end else if (distance > cfg.near_limit) begin
        on_length_next  = cfg.beep_on_ticks;
        off_length_next = cfg.mid_off_ticks;
        level_held_next = LVL_MID;
      end else if (distance > cfg.contact_limit) begin
        on_length_next  = cfg.beep_on_ticks;
        off_length_next = cfg.near_off_ticks;
        level_held_next = LVL_NEAR;
      end else begin
        on_length_next   = STEADY_ON_TICKS;
        off_length_next  = STEADY_OFF_TICKS;
        steady_mark_next = 1'b1;
        level_held_next  = LVL_STEADY;
      end
    end
  end

  // Phase counter: on expiry toggles the phase, or holds it low while silent, and reloads from the new lengths.
  always_comb begin
    phase_count_next = phase_count;
    phase_high_next  = phase_high;
    drive_level_next = drive_level;
    if (phase_count != '0) begin
      phase_count_next = phase_count - 1'b1;
    end else if (!silent_mark_next) begin
      if (!phase_high) begin
        phase_high_next  = 1'b1;
        phase_count_next = on_length_next;
        drive_level_next = 1'b1;
      end else begin
        phase_high_next  = 1'b0;
        phase_count_next = off_length_next;
        if (!steady_mark_next) begin
          drive_level_next = 1'b0;
        end
      end
    end else begin
      phase_high_next  = 1'b0;
      phase_count_next = off_length_next;
      drive_level_next = 1'b0;
    end
  end

  assign result.speaker_on  = drive_level_next;
  assign result.alarm_level = level_held_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_distance <= NO_OBJECT_CODE - 1'b1;
      on_length     <= '0;
      off_length    <= IDLE_OFF_TICKS;
      phase_count   <= '0;
      phase_high    <= 1'b0;
      silent_mark   <= 1'b1;
      steady_mark   <= 1'b1;
      drive_level   <= 1'b0;
      level_held    <= LVL_SILENT;
    end else if (advance) begin
      held_distance <= held_distance_next;
      on_length     <= on_length_next;
      off_length    <= off_length_next;
      phase_count   <= phase_count_next;
      phase_high    <= phase_high_next;
      silent_mark   <= silent_mark_next;
      steady_mark   <= steady_mark_next;
      drive_level   <= drive_level_next;
      level_held    <= level_held_next;
    end
  end

  // The high phase always has the speaker sounding.
  a_high_drives: assert property (@(posedge clk) disable iff (rst)
    phase_high |-> drive_level)
    else $error("high phase with speaker off");

  a_silent_level: assert property (@(posedge clk) disable iff (rst)
    silent_mark |-> level_held == LVL_SILENT)
    else $error("silent mark at a sounding level");

  a_steady_marks: assert property (@(posedge clk) disable iff (rst)
    level_held == LVL_STEADY |-> steady_mark && !silent_mark)
    else $error("continuous level with wrong marks");

  // A running phase finishes first; the speaker is forced off when it expires.
  a_silent_quiet: assert property (@(posedge clk) disable iff (rst)
    advance && silent_mark_next && phase_count == '0 |=> !drive_level && !phase_high)
    else $error("speaker driven while silent");

endmodule

`default_nettype wire
